### rtl/core/dtep_pkg.sv
// types and constants shared by the der tlv element parser
`timescale 1ns / 1ps
package dtep_pkg;

  typedef enum logic [2:0] {
    PH_TAG,
    PH_LEN1,
    PH_LENN,
    PH_CONT,
    PH_UNUSED,
    PH_SKIP,
    PH_DRAIN
  } phase_t;

  typedef enum logic [2:0] {
    KIND_HDR     = 3'd0,
    KIND_SKIP    = 3'd1,
    KIND_INT     = 3'd2,
    KIND_BOOL    = 3'd3,
    KIND_BITS    = 3'd4,
    KIND_BITS_NU = 3'd5
  } kind_t;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_OUT_OF_DATA = 3'd1;
  localparam logic [2:0] ST_BAD_TAG     = 3'd2;
  localparam logic [2:0] ST_BAD_LENGTH  = 3'd3;
  localparam logic [2:0] ST_BAD_DATA    = 3'd4;
  localparam logic [2:0] ST_MISMATCH    = 3'd5;

  localparam logic [7:0] TAG_BOOL = 8'h01;
  localparam logic [7:0] TAG_INT  = 8'h02;
  localparam logic [7:0] TAG_BITS = 8'h03;

  localparam logic [30:0] INT_MAX31 = 31'h7FFF_FFFF;
  localparam logic [30:0] INT_SAT_LIMIT = 31'h007F_FFFF;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [31:0] bytes_left;
    logic [2:0]  command;
    logic [7:0]  expected_tag;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  tag_seen;
    logic [31:0] content_length;
    logic [30:0] int_value;
    logic [2:0]  pad_bits;
  } out_item_t;

  // classified byte as held in the queue
  typedef struct packed {
    logic [7:0]  data_byte;
    logic [31:0] bl;
    logic [31:0] rem;
    logic        last;
    kind_t       kind;
    logic [7:0]  want_tag;
  } cls_item_t;

endpackage

### rtl/core/der_tlv_element_parser.sv
// der tlv element parser top level
//
//  channel | dir | handshake           | payload
//  in_     | in  | in_valid / in_stall   | dtep_pkg::in_item_t
//  out_    | out | out_valid / out_stall | dtep_pkg::out_item_t
//
// one byte per cycle while the result is not stalled, set by the single parsing state machine in the back end
// bytes are written into the queue; a result's valid rises at the edge that pops its byte from the queue
// synchronous active-low reset clears queue, state machine and result valid
// a stalled result holds the back end; the two-entry queue fills, then in_stall rises
`timescale 1ns / 1ps
module der_tlv_element_parser #(
  parameter int MAX_LENGTH_BYTES = 4,
  parameter int INT_BYTES = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  dtep_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output dtep_pkg::out_item_t out_item
);

  logic                q_valid, q_pop;
  dtep_pkg::cls_item_t q_item;

  dtep_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item)
  );

  dtep_back #(
    .MAX_LENGTH_BYTES(MAX_LENGTH_BYTES), .INT_BYTES(INT_BYTES)
  ) u_back (
    .clk(clk), .rst_n(rst_n),
    .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
  );

  a_pop_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid) else $error("pop from empty queue");

  a_err_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status != dtep_pkg::ST_OK) |->
      (out_item.content_length == 32'd0 && out_item.int_value == 31'd0 &&
       out_item.pad_bits == 3'd0)) else $error("error result carries data");

  a_result_from_pop: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(q_pop)) else $error("result without a byte");

endmodule

### rtl/core/dtep_front.sv
// front end: accepts and classifies bytes into a short queue
`timescale 1ns / 1ps
module dtep_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  dtep_pkg::in_item_t  in_item,
  output logic                q_valid,
  input  logic                q_pop,
  output dtep_pkg::cls_item_t q_item
);

  localparam int QDEPTH = 2;
  localparam int PW = $clog2(QDEPTH);

  dtep_pkg::cls_item_t q_r [QDEPTH];
  dtep_pkg::cls_item_t cls;
  logic [PW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [PW:0]   cnt_r, cnt_nxt;
  logic          push;

  always_comb begin
    cls.data_byte = in_item.data_byte;
    cls.bl = (in_item.bytes_left == 32'd0) ? 32'd1 : in_item.bytes_left;
    cls.rem = cls.bl - 32'd1;
    cls.last = (cls.bl == 32'd1);
    case (in_item.command)
      dtep_pkg::KIND_SKIP:    cls.kind = dtep_pkg::KIND_SKIP;
      dtep_pkg::KIND_INT:     cls.kind = dtep_pkg::KIND_INT;
      dtep_pkg::KIND_BOOL:    cls.kind = dtep_pkg::KIND_BOOL;
      dtep_pkg::KIND_BITS:    cls.kind = dtep_pkg::KIND_BITS;
      dtep_pkg::KIND_BITS_NU: cls.kind = dtep_pkg::KIND_BITS_NU;
      default:                cls.kind = dtep_pkg::KIND_HDR;
    endcase
    case (cls.kind)
      dtep_pkg::KIND_INT:                        cls.want_tag = dtep_pkg::TAG_INT;
      dtep_pkg::KIND_BOOL:                       cls.want_tag = dtep_pkg::TAG_BOOL;
      dtep_pkg::KIND_BITS, dtep_pkg::KIND_BITS_NU: cls.want_tag = dtep_pkg::TAG_BITS;
      default:                                   cls.want_tag = in_item.expected_tag;
    endcase
  end

  assign in_stall = (cnt_r == (PW+1)'(QDEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != '0);
  assign q_item   = q_r[rp_r];

  always_comb begin
    wp_nxt  = push ? PW'(wp_r + 1'b1) : wp_r;
    rp_nxt  = q_pop ? PW'(rp_r + 1'b1) : rp_r;
    cnt_nxt = cnt_r + (PW+1)'(push) - (PW+1)'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= cls;
    end
  end

endmodule

### rtl/core/dtep_back.sv
// back end: tlv parsing state machine and result register
`timescale 1ns / 1ps
module dtep_back #(
  parameter int MAX_LENGTH_BYTES = 4,
  parameter int INT_BYTES = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  output logic                q_pop,
  input  dtep_pkg::cls_item_t q_item,
  output logic                out_valid,
  input  logic                out_stall,
  output dtep_pkg::out_item_t out_item
);

  dtep_pkg::phase_t phase_r, phase_nxt;
  dtep_pkg::kind_t  kind_r, kind_nxt;
  logic [7:0]  tag_r, tag_nxt;
  logic [31:0] len_r, len_nxt;
  logic [2:0]  pend_r, pend_nxt;
  logic [31:0] cc_r, cc_nxt;
  logic [30:0] val_r, val_nxt;
  logic        out_valid_r, out_valid_nxt;
  dtep_pkg::out_item_t out_r, out_nxt;

  logic [7:0]  b;
  logic [31:0] len_cur, cc_m1, len_m1;
  logic [30:0] newv;
  logic [2:0]  pend_m1;
  logic [6:0]  n;
  logic        fin, ev_fail, ev_ok;
  logic [2:0]  ev_status;
  logic [31:0] ok_len;
  logic [30:0] ok_val;
  logic [2:0]  ok_ub;

  assign q_pop = q_valid && (!out_valid_r || !out_stall);
  assign b = q_item.data_byte;
  assign n = b[6:0];
  assign pend_m1 = pend_r - 3'd1;
  assign cc_m1 = cc_r - 32'd1;
  assign len_m1 = len_r - 32'd1;
  assign newv = (val_r > dtep_pkg::INT_SAT_LIMIT) ? dtep_pkg::INT_MAX31 : {val_r[22:0], b};
  assign len_cur = (phase_r == dtep_pkg::PH_LEN1) ? {24'd0, b} : {len_r[23:0], b};
  assign fin = ((phase_r == dtep_pkg::PH_LEN1) && !b[7]) ||
               ((phase_r == dtep_pkg::PH_LENN) && (pend_m1 == 3'd0));

  // event decode
  always_comb begin
    ev_fail = 1'b0;
    ev_ok = 1'b0;
    ev_status = dtep_pkg::ST_OK;
    ok_len = '0;
    ok_val = '0;
    ok_ub = '0;
    case (phase_r)
      dtep_pkg::PH_TAG: begin
        if (b != q_item.want_tag) begin
          ev_fail = 1'b1; ev_status = dtep_pkg::ST_BAD_TAG;
        end else if (q_item.rem == 32'd0) begin
          ev_fail = 1'b1; ev_status = dtep_pkg::ST_OUT_OF_DATA;
        end
      end
      dtep_pkg::PH_LEN1, dtep_pkg::PH_LENN: begin
        if (fin) begin
          ok_len = len_cur;
          if (len_cur > q_item.rem) begin
            ev_fail = 1'b1; ev_status = dtep_pkg::ST_OUT_OF_DATA;
          end else begin
            case (kind_r)
              dtep_pkg::KIND_HDR, dtep_pkg::KIND_SKIP: ev_ok = 1'b1;
              dtep_pkg::KIND_INT: begin
                if (len_cur == 32'd0 || len_cur > 32'(INT_BYTES)) begin
                  ev_fail = 1'b1; ev_status = dtep_pkg::ST_BAD_LENGTH;
                end
              end
              dtep_pkg::KIND_BOOL: begin
                if (len_cur != 32'd1) begin
                  ev_fail = 1'b1; ev_status = dtep_pkg::ST_BAD_LENGTH;
                end
              end
              dtep_pkg::KIND_BITS: begin
                if (len_cur == 32'd0) begin
                  ev_fail = 1'b1; ev_status = dtep_pkg::ST_OUT_OF_DATA;
                end
              end
              default: begin
                if (len_cur < 32'd2) begin
                  ev_fail = 1'b1; ev_status = dtep_pkg::ST_BAD_DATA;
                end
              end
            endcase
          end
        end else if (phase_r == dtep_pkg::PH_LEN1) begin
          if (n == 7'd0 || n > 7'(MAX_LENGTH_BYTES)) begin
            ev_fail = 1'b1; ev_status = dtep_pkg::ST_BAD_LENGTH;
          end else if (q_item.rem < {25'd0, n}) begin
            ev_fail = 1'b1; ev_status = dtep_pkg::ST_OUT_OF_DATA;
          end
        end else if (q_item.rem < {29'd0, pend_m1}) begin
          ev_fail = 1'b1; ev_status = dtep_pkg::ST_OUT_OF_DATA;
        end
      end
      dtep_pkg::PH_CONT: begin
        if (kind_r == dtep_pkg::KIND_BOOL) begin
          ev_ok = 1'b1; ok_len = 32'd1; ok_val = {30'd0, b != 8'd0};
        end else if (cc_r == len_r && b[7]) begin
          ev_fail = 1'b1; ev_status = dtep_pkg::ST_BAD_LENGTH;
        end else if (cc_m1 == 32'd0) begin
          ev_ok = 1'b1; ok_len = len_r; ok_val = newv;
        end else if (q_item.rem < cc_m1) begin
          ev_fail = 1'b1; ev_status = dtep_pkg::ST_OUT_OF_DATA;
        end
      end
      dtep_pkg::PH_UNUSED: begin
        ok_len = len_m1;
        if (kind_r == dtep_pkg::KIND_BITS) begin
          ok_ub = b[2:0];
          if (b > 8'd7) begin
            ev_fail = 1'b1; ev_status = dtep_pkg::ST_BAD_LENGTH;
          end else if (q_item.bl != len_r) begin
            ev_fail = 1'b1; ev_status = dtep_pkg::ST_MISMATCH;
          end else begin
            ev_ok = 1'b1;
          end
        end else if (b != 8'd0) begin
          ev_fail = 1'b1; ev_status = dtep_pkg::ST_BAD_DATA;
        end else begin
          ev_ok = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // next state
  always_comb begin
    phase_nxt = phase_r;
    if (ev_fail) begin
      phase_nxt = q_item.last ? dtep_pkg::PH_TAG : dtep_pkg::PH_DRAIN;
    end else begin
      case (phase_r)
        dtep_pkg::PH_TAG: phase_nxt = dtep_pkg::PH_LEN1;
        dtep_pkg::PH_LEN1, dtep_pkg::PH_LENN: begin
          if (!fin) begin
            phase_nxt = dtep_pkg::PH_LENN;
          end else begin
            case (kind_r)
              dtep_pkg::KIND_HDR:  phase_nxt = dtep_pkg::PH_TAG;
              dtep_pkg::KIND_SKIP: begin
                phase_nxt = (len_cur == 32'd0) ? dtep_pkg::PH_TAG : dtep_pkg::PH_SKIP;
              end
              dtep_pkg::KIND_INT, dtep_pkg::KIND_BOOL: phase_nxt = dtep_pkg::PH_CONT;
              default: phase_nxt = dtep_pkg::PH_UNUSED;
            endcase
          end
        end
        dtep_pkg::PH_CONT: phase_nxt = ev_ok ? dtep_pkg::PH_TAG : dtep_pkg::PH_CONT;
        dtep_pkg::PH_UNUSED: begin
          phase_nxt = (len_m1 == 32'd0 || q_item.last) ? dtep_pkg::PH_TAG : dtep_pkg::PH_SKIP;
        end
        dtep_pkg::PH_SKIP: begin
          phase_nxt = (cc_m1 == 32'd0 || q_item.last) ? dtep_pkg::PH_TAG : dtep_pkg::PH_SKIP;
        end
        dtep_pkg::PH_DRAIN: phase_nxt = q_item.last ? dtep_pkg::PH_TAG : dtep_pkg::PH_DRAIN;
        default: phase_nxt = dtep_pkg::PH_TAG;
      endcase
    end
  end

  // datapath registers and result
  always_comb begin
    kind_nxt = kind_r;
    tag_nxt = tag_r;
    len_nxt = len_r;
    pend_nxt = pend_r;
    cc_nxt = cc_r;
    val_nxt = val_r;
    case (phase_r)
      dtep_pkg::PH_TAG: begin
        kind_nxt = q_item.kind;
        tag_nxt = b;
      end
      dtep_pkg::PH_LEN1, dtep_pkg::PH_LENN: begin
        if (phase_r == dtep_pkg::PH_LEN1 && b[7]) begin
          len_nxt = '0;
          pend_nxt = n[2:0];
        end else begin
          len_nxt = len_cur;
          pend_nxt = pend_m1;
        end
        if (fin) begin
          cc_nxt = (kind_r == dtep_pkg::KIND_BOOL) ? 32'd1 : len_cur;
          val_nxt = '0;
        end
      end
      dtep_pkg::PH_CONT: begin
        cc_nxt = cc_m1;
        val_nxt = newv;
      end
      dtep_pkg::PH_UNUSED: cc_nxt = len_m1;
      dtep_pkg::PH_SKIP:   cc_nxt = cc_m1;
      default: begin
      end
    endcase

    out_valid_nxt = q_pop ? (ev_fail || ev_ok) : (out_valid_r && out_stall);
    out_nxt = out_r;
    if (q_pop) begin
      out_nxt.status = ev_status;
      out_nxt.tag_seen = (phase_r == dtep_pkg::PH_TAG) ? b : tag_r;
      out_nxt.content_length = ev_fail ? 32'd0 : ok_len;
      out_nxt.int_value = ev_fail ? 31'd0 : ok_val;
      out_nxt.pad_bits = ev_fail ? 3'd0 : ok_ub;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= dtep_pkg::PH_TAG;
      kind_r <= dtep_pkg::KIND_HDR;
      tag_r <= '0;
      len_r <= '0;
      pend_r <= '0;
      cc_r <= '0;
      val_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (q_pop) begin
        phase_r <= phase_nxt;
        kind_r <= kind_nxt;
        tag_r <= tag_nxt;
        len_r <= len_nxt;
        pend_r <= pend_nxt;
        cc_r <= cc_nxt;
        val_r <= val_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item = out_r;

endmodule

### tb/der_tlv_element_parser_chk.sv
// checker that predicts the parser's results and compares them with the out channel
`timescale 1ns / 1ps
module der_tlv_element_parser_chk #(
  parameter int MAX_LENGTH_BYTES = 4,
  parameter int INT_BYTES = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  dtep_pkg::in_item_t  in_item,
  input  logic                out_valid,
  input  logic                out_stall,
  input  dtep_pkg::out_item_t out_item,
  output int                  fail_count,
  output int                  pending,
  output int                  results_seen
);

  dtep_pkg::phase_t    ph;
  dtep_pkg::kind_t     knd;
  logic [7:0]          tag_q;
  logic [31:0]         len_acc;
  logic [2:0]          len_pend;
  logic [31:0]         cnt;
  logic [31:0]         val;
  dtep_pkg::out_item_t want_q[$];

  function automatic dtep_pkg::out_item_t mk(logic [2:0] st, logic [7:0] tg,
                                             logic [31:0] ln, logic [30:0] v,
                                             logic [2:0] ub);
    dtep_pkg::out_item_t r;
    r.status = st;
    r.tag_seen = tg;
    r.content_length = ln;
    r.int_value = v;
    r.pad_bits = ub;
    return r;
  endfunction

  task automatic reject(logic [2:0] st, logic [7:0] tg, logic [31:0] bl);
    ph = (bl <= 1) ? dtep_pkg::PH_TAG : dtep_pkg::PH_DRAIN;
    want_q.push_back(mk(st, tg, 32'd0, 31'd0, 3'd0));
  endtask

  task automatic header_done(logic [31:0] rem, logic [31:0] bl);
    if (len_acc > rem) begin
      reject(dtep_pkg::ST_OUT_OF_DATA, tag_q, bl);
      return;
    end
    case (knd)
      dtep_pkg::KIND_HDR: begin
        ph = dtep_pkg::PH_TAG;
        want_q.push_back(mk(dtep_pkg::ST_OK, tag_q, len_acc, 31'd0, 3'd0));
      end
      dtep_pkg::KIND_SKIP: begin
        cnt = len_acc;
        ph = (len_acc == 0) ? dtep_pkg::PH_TAG : dtep_pkg::PH_SKIP;
        want_q.push_back(mk(dtep_pkg::ST_OK, tag_q, len_acc, 31'd0, 3'd0));
      end
      dtep_pkg::KIND_INT: begin
        if (len_acc == 0 || len_acc > 32'(INT_BYTES)) begin
          reject(dtep_pkg::ST_BAD_LENGTH, tag_q, bl);
        end else begin
          cnt = len_acc;
          val = 0;
          ph = dtep_pkg::PH_CONT;
        end
      end
      dtep_pkg::KIND_BOOL: begin
        if (len_acc != 1) reject(dtep_pkg::ST_BAD_LENGTH, tag_q, bl);
        else begin
          cnt = 1;
          ph = dtep_pkg::PH_CONT;
        end
      end
      dtep_pkg::KIND_BITS: begin
        if (len_acc < 1) reject(dtep_pkg::ST_OUT_OF_DATA, tag_q, bl);
        else ph = dtep_pkg::PH_UNUSED;
      end
      default: begin
        if (len_acc < 2) reject(dtep_pkg::ST_BAD_DATA, tag_q, bl);
        else ph = dtep_pkg::PH_UNUSED;
      end
    endcase
  endtask

  task automatic parse_byte(dtep_pkg::in_item_t it);
    logic [7:0]  b;
    logic [31:0] bl;
    logic [31:0] rem;
    logic [7:0]  wt;
    logic [31:0] n;
    b = it.data_byte;
    bl = (it.bytes_left == 0) ? 32'd1 : it.bytes_left;
    rem = bl - 1;
    case (ph)
      dtep_pkg::PH_TAG: begin
        knd = (it.command > dtep_pkg::KIND_BITS_NU) ? dtep_pkg::KIND_HDR :
              dtep_pkg::kind_t'(it.command);
        tag_q = b;
        if (knd == dtep_pkg::KIND_HDR || knd == dtep_pkg::KIND_SKIP) wt = it.expected_tag;
        else if (knd == dtep_pkg::KIND_INT) wt = dtep_pkg::TAG_INT;
        else if (knd == dtep_pkg::KIND_BOOL) wt = dtep_pkg::TAG_BOOL;
        else wt = dtep_pkg::TAG_BITS;
        if (b != wt) reject(dtep_pkg::ST_BAD_TAG, b, bl);
        else if (rem < 1) reject(dtep_pkg::ST_OUT_OF_DATA, b, bl);
        else ph = dtep_pkg::PH_LEN1;
      end
      dtep_pkg::PH_LEN1: begin
        if (!b[7]) begin
          len_acc = {24'd0, b};
          header_done(rem, bl);
        end else begin
          n = {25'd0, b[6:0]};
          if (n == 0 || n > 32'(MAX_LENGTH_BYTES)) reject(dtep_pkg::ST_BAD_LENGTH, tag_q, bl);
          else if (rem < n) reject(dtep_pkg::ST_OUT_OF_DATA, tag_q, bl);
          else begin
            len_acc = 0;
            len_pend = n[2:0];
            ph = dtep_pkg::PH_LENN;
          end
        end
      end
      dtep_pkg::PH_LENN: begin
        len_acc = {len_acc[23:0], b};
        len_pend = len_pend - 3'd1;
        if (len_pend == 0) header_done(rem, bl);
        else if (rem < {29'd0, len_pend}) reject(dtep_pkg::ST_OUT_OF_DATA, tag_q, bl);
      end
      dtep_pkg::PH_CONT: begin
        if (knd == dtep_pkg::KIND_BOOL) begin
          ph = dtep_pkg::PH_TAG;
          want_q.push_back(mk(dtep_pkg::ST_OK, tag_q, 32'd1, {30'd0, b != 0}, 3'd0));
        end else if (cnt == len_acc && b[7]) begin
          reject(dtep_pkg::ST_BAD_LENGTH, tag_q, bl);
        end else begin
          if (val > 32'h007F_FFFF) val = 32'h7FFF_FFFF;
          else val = {val[23:0], b};
          cnt = cnt - 1;
          if (cnt == 0) begin
            ph = dtep_pkg::PH_TAG;
            want_q.push_back(mk(dtep_pkg::ST_OK, tag_q, len_acc, val[30:0], 3'd0));
          end else if (rem < cnt) reject(dtep_pkg::ST_OUT_OF_DATA, tag_q, bl);
        end
      end
      dtep_pkg::PH_UNUSED: begin
        if (knd == dtep_pkg::KIND_BITS && b > 7) begin
          reject(dtep_pkg::ST_BAD_LENGTH, tag_q, bl);
        end else if (knd == dtep_pkg::KIND_BITS && bl != len_acc) begin
          reject(dtep_pkg::ST_MISMATCH, tag_q, bl);
        end else if (knd != dtep_pkg::KIND_BITS && b != 0) begin
          reject(dtep_pkg::ST_BAD_DATA, tag_q, bl);
        end else begin
          cnt = len_acc - 1;
          ph = (cnt == 0 || bl <= 1) ? dtep_pkg::PH_TAG : dtep_pkg::PH_SKIP;
          want_q.push_back(mk(dtep_pkg::ST_OK, tag_q, cnt, 31'd0,
                              (knd == dtep_pkg::KIND_BITS) ? b[2:0] : 3'd0));
        end
      end
      dtep_pkg::PH_SKIP: begin
        cnt = cnt - 1;
        if (cnt == 0 || bl <= 1) ph = dtep_pkg::PH_TAG;
      end
      dtep_pkg::PH_DRAIN: begin
        if (bl <= 1) ph = dtep_pkg::PH_TAG;
      end
      default: ph = dtep_pkg::PH_TAG;
    endcase
  endtask

  always @(posedge clk) begin
    dtep_pkg::out_item_t w;
    if (!rst_n) begin
      ph = dtep_pkg::PH_TAG;
      knd = dtep_pkg::KIND_HDR;
      tag_q = 0;
      len_acc = 0;
      len_pend = 0;
      cnt = 0;
      val = 0;
      want_q.delete();
      fail_count <= 0;
      results_seen <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen <= results_seen + 1;
        if (want_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %p", $time, out_item);
          fail_count <= fail_count + 1;
        end else begin
          w = want_q.pop_front();
          if (w !== out_item) begin
            $display("%0t: mismatch, expected %p, actual %p", $time, w, out_item);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_valid && !in_stall) parse_byte(in_item);
    end
    pending <= want_q.size();
  end

endmodule

### tb/der_tlv_element_parser_tb.sv
// testbench top: drives der element streams and gives the verdict
`timescale 1ns / 1ps
module der_tlv_element_parser_tb;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  dtep_pkg::in_item_t  in_item;
  logic                out_valid;
  logic                out_stall;
  dtep_pkg::out_item_t out_item;
  int                  fail_count;
  int                  pending;
  int                  results_seen;
  int                  cycles;
  int                  sent;
  int                  burst;
  int                  gap;
  int                  stall_mode;

  dtep_pkg::in_item_t  byte_q[$];

  der_tlv_element_parser DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
  );

  der_tlv_element_parser_chk chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .fail_count(fail_count), .pending(pending), .results_seen(results_seen)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 200000) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // receiver stall pattern
  initial begin
    out_stall = 0;
    stall_mode = 0;
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
        0: out_stall <= 0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 1) == 0);
        default: out_stall <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // region of bytes with given cmd/tag only on the first byte of each element
  task automatic put(logic [7:0] b, logic [2:0] cmd = dtep_pkg::KIND_HDR,
                     logic [7:0] et = 0);
    dtep_pkg::in_item_t it;
    it.data_byte = b;
    it.bytes_left = 0;
    it.command = cmd;
    it.expected_tag = et;
    byte_q.push_back(it);
  endtask

  // assign bytes_left counting back from the end of the region just built; with wild set, some get random values
  task automatic close_region(int start, logic wild);
    int n;
    n = byte_q.size() - start;
    for (int i = start; i < byte_q.size(); i++) begin
      byte_q[i].bytes_left = 32'(n - (i - start));
      if (wild && $urandom_range(0, 15) == 0) byte_q[i].bytes_left = $urandom;
    end
    if (n > 0 && $urandom_range(0, 7) == 0) byte_q[byte_q.size() - 1].bytes_left = 0;
  endtask

  task automatic put_len(int len, int form);
    if (form == 0 && len < 128) put(len[7:0]);
    else begin
      int nb;
      nb = (form > 0) ? form : 4;
      put(8'h80 | nb[7:0]);
      for (int i = nb - 1; i >= 0; i--) put(len[8*i +: 8]);
    end
  endtask

  task automatic rand_element();
    int k;
    int len;
    logic [7:0] t;
    k = $urandom_range(0, 7);
    len = $urandom_range(0, 5);
    case (k)
      0, 1, 6, 7: begin
        t = 8'($urandom);
        put(t, k[2:0], ($urandom_range(0, 7) == 0) ? 8'($urandom) : t);
        put_len(len, ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0);
        if (k == 1) for (int i = 0; i < len; i++) put(8'($urandom));
      end
      2: begin
        len = $urandom_range(1, 5);
        put(dtep_pkg::TAG_INT, dtep_pkg::KIND_INT);
        put_len(len, ($urandom_range(0, 5) == 0) ? $urandom_range(1, 2) : 0);
        for (int i = 0; i < len; i++)
          put((i == 0 && $urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 127)) :
              8'($urandom));
      end
      3: begin
        len = ($urandom_range(0, 7) == 0) ? 2 : 1;
        put(dtep_pkg::TAG_BOOL, dtep_pkg::KIND_BOOL);
        put_len(len, 0);
        for (int i = 0; i < len; i++)
          put(($urandom_range(0, 1) == 0) ? 8'd0 : 8'($urandom));
      end
      default: begin
        len = $urandom_range(0, 4);
        put(dtep_pkg::TAG_BITS, k[2:0]);
        put_len(len, 0);
        if (len > 0)
          put(($urandom_range(0, 5) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7)));
        for (int i = 1; i < len; i++) put(8'($urandom));
      end
    endcase
    if ($urandom_range(0, 19) == 0) put(8'($urandom), 3'($urandom), 8'($urandom));
  endtask

  task automatic build_directed();
    int s;
    s = byte_q.size(); put(8'h30, dtep_pkg::KIND_HDR, 8'h30); put(8'h00); close_region(s, 0);
    // unknown command acts as header
    s = byte_q.size(); put(8'hFF, 3'd7, 8'hFF); put(8'h84); put(8'h00); put(8'h00);
    put(8'h00); put(8'h01); put(8'hAA); close_region(s, 0);
    s = byte_q.size(); put(dtep_pkg::TAG_INT, dtep_pkg::KIND_INT); put(8'h04); put(8'h7F);
    put(8'hFF); put(8'hFF); put(8'hFF); close_region(s, 0);
    s = byte_q.size(); put(dtep_pkg::TAG_INT, dtep_pkg::KIND_INT); put(8'h01); put(8'h80);
    put(8'h00); close_region(s, 0);
    s = byte_q.size(); put(dtep_pkg::TAG_BOOL, dtep_pkg::KIND_BOOL); put(8'h01); put(8'hFF);
    close_region(s, 0);
    s = byte_q.size(); put(dtep_pkg::TAG_BITS, dtep_pkg::KIND_BITS); put(8'h02); put(8'h07);
    put(8'hF0); close_region(s, 0);
    s = byte_q.size(); put(dtep_pkg::TAG_BITS, dtep_pkg::KIND_BITS_NU); put(8'h02);
    put(8'h00); put(8'h55); put(8'h00); close_region(s, 0);
    s = byte_q.size(); put(8'h04, dtep_pkg::KIND_SKIP, 8'h05); put(8'h01); close_region(s, 0);
    // unknown command acts as header
    s = byte_q.size(); put(8'h04, 3'd6, 8'h04); close_region(s, 0);
    s = byte_q.size(); put(8'h04, dtep_pkg::KIND_HDR, 8'h04); put(8'h85); put(8'h00);
    close_region(s, 0);
  endtask

  initial begin
    int s;
    rst_n = 0;
    in_valid = 0;
    in_item = '0;
    build_directed();
    while (byte_q.size() < 1150) begin
      s = byte_q.size();
      repeat ($urandom_range(1, 4)) rand_element();
      close_region(s, $urandom_range(0, 5) == 0);
    end
    repeat (10) @(posedge clk);
    rst_n <= 1;
    sent = 0;
    while (byte_q.size() > 0) begin
      burst = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      while (burst > 0 && byte_q.size() > 0) begin
        in_valid <= 1;
        in_item <= byte_q.pop_front();
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sent++;
        burst--;
      end
      if (gap > 0) begin
        in_valid <= 0;
        in_item.data_byte <= 8'($urandom);
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("sent %0d bytes in element streams, checked %0d parser results",
             sent, results_seen);
    if (fail_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule
